// ===== sv/rrts_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and defaults for the round-robin task slot scheduler
// no dependencies

package rrts_pkg;

	localparam int SLOT_COUNT_DEF = 16;

	localparam logic [2:0] CMD_SPAWN  = 3'd0;
	localparam logic [2:0] CMD_YIELD  = 3'd1;
	localparam logic [2:0] CMD_TICK   = 3'd2;
	localparam logic [2:0] CMD_FINISH = 3'd3;

	localparam logic [1:0] ST_EMPTY   = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;
	localparam logic [1:0] ST_DONE    = 2'd3;

	typedef struct packed {
		logic [2:0] command;
		logic [3:0] query_slot;
	} request_t;

	typedef struct packed {
		logic        status;
		logic [3:0]  task_index;
		logic        current_valid;
		logic [3:0]  current_task;
		logic [31:0] tick_total;
		logic [1:0]  slot_state;
		logic [31:0] slot_runs;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_DISPATCH,
		S_BUMP,
		S_CLAIM,
		S_QUERY,
		S_REPLY
	} fsm_state_t;

	typedef struct packed {
		logic accept;
		logic prep;
		logic scan_step;
		logic miss;
		logic dispatch;
		logic bump;
		logic claim;
		logic query;
		logic reply;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_spawn;
		logic hit;
		logic exhausted;
	} dp_status_t;

	function automatic logic cmd_uses_scan(input logic [2:0] c);
		return (c == CMD_SPAWN) || (c == CMD_YIELD) || (c == CMD_TICK) || (c == CMD_FINISH);
	endfunction

endpackage

// ===== sv/rrts_ram.sv =====
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies

module rrts_ram #(
	parameter int W = 32,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/rrts_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for the scheduler: accept, slot scan, dispatch or claim, query, reply
// depends on rrts_pkg

module rrts_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [2:0]             command,
	input  rrts_pkg::dp_status_t   st,
	output logic                   busy,
	output rrts_pkg::ctrl_cmd_t    cmd
);

	rrts_pkg::fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rrts_pkg::S_IDLE: begin
				if (start) begin
					state_d = rrts_pkg::cmd_uses_scan(command) ? rrts_pkg::S_PREP
						: rrts_pkg::S_QUERY;
				end
			end
			rrts_pkg::S_PREP: begin
				state_d = rrts_pkg::S_SCAN;
			end
			rrts_pkg::S_SCAN: begin
				if (st.hit) begin
					state_d = st.is_spawn ? rrts_pkg::S_CLAIM : rrts_pkg::S_DISPATCH;
				end else if (st.exhausted) begin
					state_d = rrts_pkg::S_QUERY;
				end
			end
			rrts_pkg::S_DISPATCH: begin
				state_d = rrts_pkg::S_BUMP;
			end
			rrts_pkg::S_BUMP: begin
				state_d = rrts_pkg::S_QUERY;
			end
			rrts_pkg::S_CLAIM: begin
				state_d = rrts_pkg::S_QUERY;
			end
			rrts_pkg::S_QUERY: begin
				state_d = rrts_pkg::S_REPLY;
			end
			rrts_pkg::S_REPLY: begin
				state_d = rrts_pkg::S_IDLE;
			end
			default: begin
				state_d = rrts_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			rrts_pkg::S_IDLE: begin
				cmd.accept = start;
			end
			rrts_pkg::S_PREP: begin
				cmd.prep = 1'b1;
			end
			rrts_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.miss = !st.hit && st.exhausted;
			end
			rrts_pkg::S_DISPATCH: begin
				cmd.dispatch = 1'b1;
			end
			rrts_pkg::S_BUMP: begin
				cmd.bump = 1'b1;
			end
			rrts_pkg::S_CLAIM: begin
				cmd.claim = 1'b1;
			end
			rrts_pkg::S_QUERY: begin
				cmd.query = 1'b1;
			end
			rrts_pkg::S_REPLY: begin
				cmd.reply = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign busy = (state_q != rrts_pkg::S_IDLE);

endmodule

// ===== sv/rrts_dp.sv =====
`timescale 1ns / 1ps
// scheduler datapath: slot state and dispatch count rams, valid bits, scan pointer,
// current task, tick counter and result register; depends on rrts_pkg and rrts_ram

module rrts_dp #(
	parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rrts_pkg::request_t   request,
	input  rrts_pkg::ctrl_cmd_t  cmd,
	output rrts_pkg::dp_status_t st,
	output rrts_pkg::result_t    result,
	output logic                 strobe
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int LW = $clog2(SLOT_COUNT + 1);
	localparam int QW = IW + 4;
	localparam int VD = 1 << IW;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] a);
		return (a == IW'(SLOT_COUNT - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [3:0] low4(input logic [IW-1:0] v);
		logic [IW+3:0] e;
		e = {4'b0000, v};
		return e[3:0];
	endfunction

	logic [2:0]    cmd_q;
	logic [3:0]    qslot_q;
	logic [31:0]   tick_q;
	logic          has_cur_q;
	logic [IW-1:0] cur_q;
	logic          cur_run_q;
	logic [VD-1:0] valid_q;
	logic [IW-1:0] idx_q;
	logic [LW-1:0] left_q;
	logic          pend_q;
	logic [IW-1:0] pidx_q;
	logic [IW-1:0] fidx_q;
	logic          rval_q;
	logic          qin_q;
	logic          status_q;
	logic [3:0]    tidx_q;
	rrts_pkg::result_t result_q;
	logic          strobe_q;

	logic          st_we, cnt_we, st_re, cnt_re;
	logic [IW-1:0] st_waddr, cnt_waddr, rd_addr;
	logic [1:0]    st_wdata, st_rdata, st_seen;
	logic [31:0]   cnt_wdata, cnt_rdata, cnt_seen;
	logic          is_spawn, is_sched, is_finish, match, demote, in_range;
	logic [IW-1:0] start_idx, qaddr;
	logic [QW-1:0] qs_ext;
	logic [1:0]    tick_inc;

	assign is_spawn  = (cmd_q == rrts_pkg::CMD_SPAWN);
	assign is_finish = (cmd_q == rrts_pkg::CMD_FINISH);
	assign is_sched  = (cmd_q == rrts_pkg::CMD_YIELD) || (cmd_q == rrts_pkg::CMD_TICK) || is_finish;

	assign st_seen  = rval_q ? st_rdata : rrts_pkg::ST_EMPTY;
	assign cnt_seen = rval_q ? cnt_rdata : 32'd0;
	assign match = pend_q && (is_spawn
		? ((st_seen == rrts_pkg::ST_EMPTY) || (st_seen == rrts_pkg::ST_DONE))
		: (st_seen == rrts_pkg::ST_READY));
	assign demote    = has_cur_q && (cur_q != fidx_q) && cur_run_q;
	assign start_idx = has_cur_q ? cur_q : '0;
	assign qs_ext    = {{IW{1'b0}}, qslot_q};
	assign in_range  = (qs_ext < QW'(SLOT_COUNT));
	assign qaddr     = qs_ext[IW-1:0];

	assign st.is_spawn  = is_spawn;
	assign st.hit       = match;
	assign st.exhausted = (left_q == '0) && !pend_q;

	always_comb begin
		case (request.command)
			rrts_pkg::CMD_YIELD:  tick_inc = 2'd1;
			rrts_pkg::CMD_TICK:   tick_inc = 2'd2;
			rrts_pkg::CMD_FINISH: tick_inc = 2'd1;
			default:              tick_inc = 2'd0;
		endcase
	end

	always_comb begin
		st_we     = 1'b0;
		st_waddr  = fidx_q;
		st_wdata  = rrts_pkg::ST_RUNNING;
		st_re     = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = fidx_q;
		cnt_wdata = 32'd0;
		cnt_re    = 1'b0;
		rd_addr   = idx_q;
		if (cmd.prep && is_finish && has_cur_q) begin
			st_we    = 1'b1;
			st_waddr = cur_q;
			st_wdata = rrts_pkg::ST_DONE;
		end
		if (cmd.scan_step && (left_q != '0)) begin
			st_re   = 1'b1;
			rd_addr = idx_q;
		end
		if (cmd.dispatch) begin
			st_we    = 1'b1;
			st_wdata = rrts_pkg::ST_RUNNING;
			cnt_re   = 1'b1;
			rd_addr  = fidx_q;
		end
		if (cmd.bump) begin
			cnt_we    = 1'b1;
			cnt_wdata = cnt_seen + 32'd1;
			if (demote) begin
				st_we    = 1'b1;
				st_waddr = cur_q;
				st_wdata = rrts_pkg::ST_READY;
			end
		end
		if (cmd.claim) begin
			st_we     = 1'b1;
			st_wdata  = rrts_pkg::ST_READY;
			cnt_we    = 1'b1;
			cnt_wdata = 32'd0;
		end
		if (cmd.query) begin
			st_re   = 1'b1;
			cnt_re  = 1'b1;
			rd_addr = qaddr;
		end
	end

	rrts_ram #(.W(2), .D(SLOT_COUNT)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (rd_addr),
		.rdata (st_rdata)
	);

	rrts_ram #(.W(32), .D(SLOT_COUNT)) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (rd_addr),
		.rdata (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			has_cur_q <= 1'b0;
			cur_q     <= '0;
			cur_run_q <= 1'b0;
			valid_q   <= '0;
			pend_q    <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= cmd.reply;
			if (cmd.accept) begin
				tick_q <= tick_q + 32'(tick_inc);
			end
			if (cmd.prep) begin
				pend_q <= 1'b0;
				if (is_finish && has_cur_q) begin
					cur_run_q <= 1'b0;
				end
			end
			if (cmd.scan_step) begin
				pend_q <= (left_q != '0);
			end
			if (cmd.bump) begin
				has_cur_q <= 1'b1;
				cur_q     <= fidx_q;
				cur_run_q <= 1'b1;
			end
			if (cmd.claim) begin
				valid_q[fidx_q] <= 1'b1;
				if (fidx_q == cur_q) begin
					cur_run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q    <= request.command;
			qslot_q  <= request.query_slot;
			status_q <= 1'b0;
			tidx_q   <= 4'd0;
		end
		if (cmd.prep) begin
			left_q <= LW'(SLOT_COUNT);
			idx_q  <= is_spawn ? '0 : nxt(start_idx);
		end
		if (cmd.scan_step) begin
			if (left_q != '0) begin
				pidx_q <= idx_q;
				idx_q  <= nxt(idx_q);
				left_q <= left_q - 1'b1;
			end
			if (match) begin
				fidx_q <= pidx_q;
			end
		end
		if (st_re || cnt_re) begin
			rval_q <= valid_q[rd_addr];
		end
		if (cmd.miss) begin
			status_q <= 1'b1;
		end
		if (cmd.claim) begin
			tidx_q <= low4(fidx_q);
		end
		if (cmd.query) begin
			qin_q <= in_range;
		end
		if (cmd.reply) begin
			result_q.status        <= status_q;
			result_q.task_index    <= is_sched ? (has_cur_q ? low4(cur_q) : 4'd0) : tidx_q;
			result_q.current_valid <= has_cur_q;
			result_q.current_task  <= has_cur_q ? low4(cur_q) : 4'd0;
			result_q.tick_total    <= tick_q;
			result_q.slot_state    <= qin_q ? st_seen : rrts_pkg::ST_EMPTY;
			result_q.slot_runs     <= qin_q ? cnt_seen : 32'd0;
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

// ===== sv/round_robin_task_slot_scheduler.sv =====
`timescale 1ns / 1ps
// top level of the round-robin task slot scheduler: controller plus datapath
// depends on rrts_pkg, rrts_ctrl, rrts_dp

// A command word is taken when start is high and busy is low; busy then stays high
// until the command is finished, and exactly one result word follows, held on result
// for one cycle with strobe high. The receiver cannot stall, so it must take the word
// in that cycle. Commands other than spawn, yield, timer tick and finish go from accept
// straight to the query and reply states. Spawn, yield, timer tick and finish walk the
// slot table through one ram read port, one slot a cycle, so their run time is set by
// how far the round-robin or lowest-free search runs. No clearing pass is needed after
// reset: per-slot valid bits make untouched slots read as empty with a zero count.

module round_robin_task_slot_scheduler #(
	parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rrts_pkg::request_t request,
	output logic               busy,
	output logic               strobe,
	output rrts_pkg::result_t  result
);

	rrts_pkg::ctrl_cmd_t  cmd;
	rrts_pkg::dp_status_t st;

	rrts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.st      (st),
		.busy    (busy),
		.cmd     (cmd)
	);

	rrts_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.st      (st),
		.result  (result),
		.strobe  (strobe)
	);

endmodule

// ===== sv/rrts_chk.sv =====
`timescale 1ns / 1ps
// port-level checks for the round-robin task slot scheduler, bound to the top level
// depends on rrts_pkg and round_robin_task_slot_scheduler

module rrts_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               strobe,
	input rrts_pkg::result_t  result
);

	logic        seen_cur_q;
	logic        have_prev_q;
	logic [31:0] last_tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_cur_q  <= 1'b0;
			have_prev_q <= 1'b0;
			last_tick_q <= '0;
		end else if (strobe) begin
			seen_cur_q  <= seen_cur_q | result.current_valid;
			have_prev_q <= 1'b1;
			last_tick_q <= result.tick_total;
		end
	end

	a_one_cycle_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result word held longer than one cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted word");

	a_idle_at_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result word while still busy");

	a_current_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && seen_cur_q) |-> result.current_valid)
		else $error("current task lost after being set");

	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && have_prev_q)
			|-> (32'(result.tick_total - last_tick_q) <= 32'd2))
		else $error("tick counter moved by more than two");

endmodule

bind round_robin_task_slot_scheduler rrts_chk u_rrts_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.strobe  (strobe),
	.result  (result)
);
